@@ src/ctw_pkg.sv @@
package ctw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  // field widths
  localparam int MODE_W = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int HEX_W  = 32;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int HIDX_W = 4;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TAB   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEX   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

  // character and attribute constants
  localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] ZERO_CHAR    = 8'h30;
  localparam logic [CHAR_W-1:0] X_CHAR       = 8'h78;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam int                TAB_STEP     = 8;
  localparam int                HEX_CHARS    = 10;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam addr_t             LAST_CELL = ADDR_W'(CELLS - 1);
  localparam addr_t             KEEP_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [HIDX_W-1:0] HEX_LAST  = HIDX_W'(HEX_CHARS - 1);
  localparam logic [HIDX_W-1:0] HIDX_X    = HIDX_W'(1);

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [HEX_W-1:0]  hex_value;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } rsp_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PUT,
    S_STEP,
    S_DEL,
    S_DELW,
    S_TAB,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_RD,
    S_RDW,
    S_OUT
  } state_t;

  // uppercase hex digit for one nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = ZERO_CHAR + {4'h0, d};
    end else begin
      r = 8'h37 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

@@ src/ctw_ifs.sv @@
interface ctw_cmd_if;
  logic          valid;
  logic          ready;
  ctw_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctw_rsp_if;
  logic          valid;
  logic          ready;
  ctw_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ctw_cell_ram.sv @@
module ctw_cell_ram (
  input  logic             clk,
  input  ctw_pkg::ram_wr_t wr,
  input  ctw_pkg::addr_t   raddr,
  output ctw_pkg::cell_t   rdata
);
  import ctw_pkg::*;

  cell_t mem [CELLS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/ctw_addr_unit.sv @@
module ctw_addr_unit (
  input  logic [ctw_pkg::ROW_W-1:0] row,
  input  logic [ctw_pkg::COL_W-1:0] col,
  output ctw_pkg::addr_t            addr
);
  import ctw_pkg::*;

  localparam int PROD_W = ROW_W + $clog2(COLUMNS) + 1;

  logic [PROD_W-1:0] prod;

  // linear cell index, row major
  assign prod = PROD_W'(row) * PROD_W'(COLUMNS) + PROD_W'(col);
  assign addr = prod[ADDR_W-1:0];

endmodule

@@ src/ctw_seq.sv @@
module ctw_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ctw_pkg::ATTR_W-1:0] fill_attr,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  ctw_pkg::cmd_t              cmd_data,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output ctw_pkg::rsp_t              rsp_data,
  output ctw_pkg::ram_wr_t           ram_wr,
  output ctw_pkg::addr_t             ram_raddr,
  input  ctw_pkg::cell_t             ram_rdata
);
  import ctw_pkg::*;

  state_t              state, state_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [COL_W-1:0]    col, col_next;
  addr_t               sweep, sweep_next;
  logic [HIDX_W-1:0]   hidx, hidx_next;
  logic [HEX_W-1:0]    hexv, hexv_next;
  logic [MODE_W-1:0]   mode_r, mode_r_next;
  logic [CHAR_W-1:0]   ch_r, ch_r_next;
  logic [ROW_W-1:0]    rrow, rrow_next;
  logic [COL_W-1:0]    rcol, rcol_next;
  logic [ATTR_W-1:0]   clr_attr, clr_attr_next;
  logic                clr_op, clr_op_next;
  logic [CHAR_W-1:0]   cell_char, cell_char_next;
  logic [ATTR_W-1:0]   cell_attr, cell_attr_next;
  logic                rsp_valid_next;
  rsp_t                rsp_data_next;

  logic [ROW_W-1:0]    au_row;
  logic [COL_W-1:0]    au_col;
  addr_t               au_addr;
  logic [CHAR_W-1:0]   cur_char;
  logic [COL_W:0]      tab_sum;
  logic                rd_in_range;

  // shared address unit
  ctw_addr_unit u_addr (
    .row  (au_row),
    .col  (au_col),
    .addr (au_addr)
  );

  // character emitted in the put state
  always_comb begin
    if (mode_r == MODE_HEX) begin
      if (hidx == '0) begin
        cur_char = ZERO_CHAR;
      end else if (hidx == HIDX_X) begin
        cur_char = X_CHAR;
      end else begin
        cur_char = hex_char(hexv[HEX_W-1 -: 4]);
      end
    end else begin
      cur_char = ch_r;
    end
  end

  assign tab_sum     = {1'b0, col} + (COL_W+1)'(TAB_STEP);
  assign rd_in_range = (rrow <= LAST_ROW) && (rcol <= LAST_COL);

  // next state and register updates
  always_comb begin
    logic do_nl;
    do_nl          = 1'b0;
    state_next     = state;
    row_next       = row;
    col_next       = col;
    sweep_next     = sweep;
    hidx_next      = hidx;
    hexv_next      = hexv;
    mode_r_next    = mode_r;
    ch_r_next      = ch_r;
    rrow_next      = rrow;
    rcol_next      = rcol;
    clr_attr_next  = clr_attr;
    clr_op_next    = clr_op;
    cell_char_next = cell_char;
    cell_attr_next = cell_attr;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_data_next  = rsp_data;

    case (state)
      S_CLR: begin
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = clr_op ? S_OUT : S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          mode_r_next    = cmd_data.mode;
          ch_r_next      = cmd_data.char_code;
          hexv_next      = cmd_data.hex_value;
          rrow_next      = cmd_data.read_row;
          rcol_next      = cmd_data.read_col;
          cell_char_next = '0;
          cell_attr_next = '0;
          hidx_next      = '0;
          case (cmd_data.mode)
            MODE_PUT: state_next = S_PUT;
            MODE_DEL: state_next = S_DEL;
            MODE_TAB: state_next = S_TAB;
            MODE_CLEAR: begin
              clr_attr_next = fill_attr;
              clr_op_next   = 1'b1;
              sweep_next    = '0;
              row_next      = '0;
              col_next      = '0;
              state_next    = S_CLR;
            end
            MODE_HEX: state_next = S_PUT;
            MODE_READ: state_next = S_RD;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_PUT: begin
        if (hidx > HIDX_X) begin
          hexv_next = {hexv[HEX_W-5:0], 4'h0};
        end
        if (cur_char == NUL_CHAR) begin
          state_next = S_OUT;
        end else if (cur_char == NEWLINE_CHAR) begin
          do_nl = 1'b1;
        end else if (col == LAST_COL) begin
          do_nl = 1'b1;
        end else begin
          col_next   = col + 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (mode_r == MODE_HEX && hidx != HEX_LAST) begin
          hidx_next  = hidx + 1'b1;
          state_next = S_PUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DEL: begin
        if (row == '0 && col == '0) begin
          state_next = S_OUT;
        end else if (col == '0) begin
          col_next   = LAST_COL;
          row_next   = row - 1'b1;
          state_next = S_DELW;
        end else begin
          col_next   = col - 1'b1;
          state_next = S_DELW;
        end
      end
      S_DELW: begin
        state_next = S_OUT;
      end
      S_TAB: begin
        if (tab_sum >= (COL_W+1)'(COLUMNS)) begin
          do_nl = 1'b1;
        end else begin
          col_next   = tab_sum[COL_W-1:0];
          state_next = S_STEP;
        end
      end
      S_SCR_RD: begin
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        sweep_next = sweep + 1'b1;
        state_next = (sweep == KEEP_LAST) ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = S_STEP;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_RD: begin
        state_next = rd_in_range ? S_RDW : S_OUT;
      end
      S_RDW: begin
        cell_char_next = ram_rdata.chr;
        cell_attr_next = ram_rdata.attr;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next           = 1'b1;
          rsp_data_next.cell_char  = cell_char;
          rsp_data_next.cell_attr  = cell_attr;
          rsp_data_next.cursor_col = col;
          rsp_data_next.cursor_row = row;
          state_next               = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // newline, scrolling from the bottom row
    if (do_nl) begin
      col_next = '0;
      if (row == LAST_ROW) begin
        sweep_next = '0;
        state_next = S_SCR_RD;
      end else begin
        row_next   = row + 1'b1;
        state_next = S_STEP;
      end
    end
  end

  // outputs: handshake, address unit inputs and memory ports
  always_comb begin
    cmd_ready    = (state == S_IDLE);
    au_row       = row;
    au_col       = col;
    ram_raddr    = au_addr;
    ram_wr.en    = 1'b0;
    ram_wr.addr  = au_addr;
    ram_wr.data  = '{attr: fill_attr, chr: BLANK_CHAR};
    case (state)
      S_CLR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = sweep;
        ram_wr.data = '{attr: clr_attr, chr: BLANK_CHAR};
      end
      S_PUT: begin
        ram_wr.en   = (cur_char != NUL_CHAR) && (cur_char != NEWLINE_CHAR);
        ram_wr.data = '{attr: fill_attr, chr: cur_char};
      end
      S_DELW: begin
        ram_wr.en = 1'b1;
      end
      S_SCR_RD: begin
        ram_raddr = sweep + ADDR_W'(COLUMNS);
      end
      S_SCR_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = sweep;
        ram_wr.data = ram_rdata;
      end
      S_BLANK: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = sweep;
      end
      S_RD: begin
        au_row = rrow;
        au_col = rcol;
      end
      default: begin
        ram_wr.en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      row       <= '0;
      col       <= '0;
      sweep     <= '0;
      clr_attr  <= RESET_ATTR;
      clr_op    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      sweep     <= sweep_next;
      clr_attr  <= clr_attr_next;
      clr_op    <= clr_op_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hidx      <= hidx_next;
    hexv      <= hexv_next;
    mode_r    <= mode_r_next;
    ch_r      <= ch_r_next;
    rrow      <= rrow_next;
    rcol      <= rcol_next;
    cell_char <= cell_char_next;
    cell_attr <= cell_attr_next;
    rsp_data  <= rsp_data_next;
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLR)
    else $error("reset did not start the clearing pass");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    row <= LAST_ROW && col <= LAST_COL)
    else $error("cursor outside the screen");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_wr.en |-> ram_wr.addr <= LAST_CELL)
    else $error("cell write outside the store");

  a_scroll_src: assert property (@(posedge clk) disable iff (rst)
    state == S_SCR_RD |-> sweep <= KEEP_LAST)
    else $error("scroll read beyond the last row");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!rsp_valid || rsp_ready)) |=> rsp_valid && state == S_IDLE)
    else $error("result word not loaded");
`endif

endmodule

@@ src/text_console_writer_unit.sv @@
// put char and tab pass a step state, delete a write-back state, read a read wait state
// before the result word; null, home and out of range skip that state; unused modes go straight to it
// print hex puts ten characters; a scroll copies each cell up a row, then blanks the last row
// clear writes blanks over the screen, one cell written per cycle
// one item at a time; the next item is accepted while the result word waits
// reset: cursor home, then a clearing pass to blanks with attribute 0x0F
module text_console_writer_unit (
  input logic       clk,
  input logic       rst,
  ctw_cmd_if.sink   cmd,
  ctw_rsp_if.source rsp,
  ctw_cfg_if.sink   cfg
);
  import ctw_pkg::*;

  logic [ATTR_W-1:0] fill_attribute;
  ram_wr_t           ram_wr;
  addr_t             ram_raddr;
  cell_t             ram_rdata;

  // configuration register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attribute <= RESET_ATTR;
    end else if (cfg.valid) begin
      fill_attribute <= cfg.data;
    end
  end

  // sequencer with cursor and address unit
  ctw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .fill_attr (fill_attribute),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_data  (cmd.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // character cell store
  ctw_cell_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ sim/text_console_writer_unit_test.sv @@
module text_console_writer_unit_test;
  import ctw_pkg::*;

  // unused mode codes, decoded as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int          IDLE_PCT      = 32;
  localparam int          PHASES        = 6;
  localparam int          PHASE_WORDS   = 300;
  localparam int          STEADY_PHASE  = 3;
  localparam int          SCROLL_BUDGET = 80;
  localparam int          CFG_SETTLE    = 12;
  localparam int          DRAIN_CYCLES  = 40;
  localparam logic [127:0] HEX_GLYPHS   = "0123456789ABCDEF";

  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  ctw_cmd_if cmd_ch ();
  ctw_rsp_if rsp_ch ();
  ctw_cfg_if cfg_ch ();

  text_console_writer_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // console model state
  cell_t       model_screen [CELLS];
  int unsigned model_col;
  int unsigned model_row;
  logic [ATTR_W-1:0] model_attr;
  int unsigned model_scrolls;

  rsp_t        pending_rsp [$];
  dir_row_t    dir_tab [$];
  rsp_t        want_rsp;
  int unsigned mismatches;
  int unsigned words_sent;
  bit          steady;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic cell_t blank_glyph();
    return {model_attr, BLANK_CHAR};
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) model_screen[i] = blank_glyph();
    model_col = 0;
    model_row = 0;
  endfunction

  // line feed, scrolling up one row past the bottom
  function automatic void line_feed();
    model_col = 0;
    model_row++;
    if (model_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) model_screen[i] = model_screen[i + COLUMNS];
      for (int j = 0; j < COLUMNS; j++) model_screen[(ROWS - 1) * COLUMNS + j] = blank_glyph();
      model_row = ROWS - 1;
      model_scrolls++;
    end
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
    if (ch == NUL_CHAR) begin
      return;
    end
    if (ch == NEWLINE_CHAR) begin
      line_feed();
      return;
    end
    model_screen[model_row * COLUMNS + model_col] = {model_attr, ch};
    model_col++;
    if (model_col >= COLUMNS) line_feed();
  endfunction

  // expected result word for one command, updating the model
  function automatic rsp_t console_predict(input cmd_t c);
    rsp_t  r;
    cell_t scr_cell;
    logic [3:0] nib;
    r = '0;
    case (c.mode)
      MODE_PUT: put_glyph(c.char_code);
      MODE_DEL: begin
        if (!(model_col == 0 && model_row == 0)) begin
          if (model_col == 0) begin
            model_col = COLUMNS - 1;
            model_row--;
          end else begin
            model_col--;
          end
          model_screen[model_row * COLUMNS + model_col] = blank_glyph();
        end
      end
      MODE_TAB: begin
        model_col += TAB_STEP;
        if (model_col >= COLUMNS) line_feed();
      end
      MODE_CLEAR: wipe_screen();
      MODE_HEX: begin
        put_glyph(ZERO_CHAR);
        put_glyph(X_CHAR);
        for (int i = 7; i >= 0; i--) begin
          nib = c.hex_value[i*4 +: 4];
          put_glyph(HEX_GLYPHS[(15 - int'(nib))*8 +: 8]);
        end
      end
      MODE_READ: begin
        if (int'(c.read_row) < ROWS && int'(c.read_col) < COLUMNS) begin
          scr_cell = model_screen[int'(c.read_row) * COLUMNS + int'(c.read_col)];
          r.cell_char = scr_cell.chr;
          r.cell_attr = scr_cell.attr;
        end
      end
      default: ;
    endcase
    r.cursor_col = COL_W'(model_col);
    r.cursor_row = ROW_W'(model_row);
    return r;
  endfunction

  function automatic dir_row_t drow(
    input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch, input logic [HEX_W-1:0] hv,
    input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc, input bit typed,
    input logic [CHAR_W-1:0] ec, input logic [ATTR_W-1:0] ea,
    input logic [COL_W-1:0] ecol, input logic [ROW_W-1:0] erow);
    dir_row_t d;
    d.c     = {m, ch, hv, rr, rc};
    d.typed = typed;
    d.want  = {ec, ea, ecol, erow};
    return d;
  endfunction

  function automatic cmd_t rand_fields(input logic [MODE_W-1:0] m);
    cmd_t c;
    c.mode      = m;
    c.char_code = CHAR_W'($urandom);
    c.hex_value = $urandom;
    c.read_row  = ROW_W'($urandom);
    c.read_col  = COL_W'($urandom);
    return c;
  endfunction

  // read address, mostly over the written area
  function automatic cmd_t read_pick();
    cmd_t c;
    int unsigned p;
    c = rand_fields(MODE_READ);
    p = $urandom_range(0, 99);
    if (p < 60) begin
      c.read_row = ROW_W'($urandom_range(0, model_row));
      c.read_col = COL_W'($urandom_range(0, COLUMNS - 1));
    end else if (p < 70) begin
      c.read_row = ROW_W'(model_row);
      c.read_col = COL_W'((model_col == 0) ? 0 : model_col - 1);
    end else if (p < 90) begin
      c.read_row = ROW_W'($urandom_range(0, ROWS - 1));
      c.read_col = COL_W'($urandom_range(0, COLUMNS - 1));
    end
    return c;
  endfunction

  // offer one command word, predict on accept
  task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    model_rsp = console_predict(c);
    pending_rsp.push_back(typed ? typed_rsp : model_rsp);
    words_sent++;
  endtask

  // fill attribute write, only with the block idle
  task automatic write_fill(input logic [ATTR_W-1:0] v);
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_attr = v;
  endtask

  // one random sequence of command words
  task automatic run_sequence();
    int unsigned pick;
    int unsigned n;
    cmd_t c;
    pick = $urandom_range(0, 99);
    if (model_scrolls >= SCROLL_BUDGET && model_row == ROWS - 1) begin
      // scrolls are slow, start over from the top
      send_cmd(rand_fields(MODE_CLEAR), 1'b0, '0);
    end else if (pick < 30) begin
      // text with some reads mixed in
      n = $urandom_range(3, 30);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          c = read_pick();
        end else begin
          c = rand_fields(MODE_PUT);
          if ($urandom_range(0, 19) == 0) begin
            c.char_code = NEWLINE_CHAR;
          end else if ($urandom_range(0, 9) != 0) begin
            c.char_code = CHAR_W'($urandom_range(8'h21, 8'h7E));
          end
        end
        send_cmd(c, 1'b0, '0);
      end
    end else if (pick < 45) begin
      n = $urandom_range(3, 12);
      repeat (n) send_cmd(read_pick(), 1'b0, '0);
    end else if (pick < 55) begin
      // deletes, long runs cross column zero or reach home
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
      repeat (n) send_cmd(rand_fields(MODE_DEL), 1'b0, '0);
    end else if (pick < 63) begin
      n = $urandom_range(1, 6);
      repeat (n) send_cmd(rand_fields(MODE_TAB), 1'b0, '0);
    end else if (pick < 71) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        c = rand_fields(MODE_HEX);
        case ($urandom_range(0, 9))
          0: c.hex_value = '0;
          1: c.hex_value = '1;
          default: ;
        endcase
        send_cmd(c, 1'b0, '0);
      end
    end else if (pick < 79) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        c = rand_fields(MODE_PUT);
        c.char_code = NEWLINE_CHAR;
        send_cmd(c, 1'b0, '0);
      end
    end else if (pick < 80) begin
      send_cmd(rand_fields(MODE_CLEAR), 1'b0, '0);
    end else begin
      // noise, every field random
      n = $urandom_range(1, 4);
      repeat (n) send_cmd(rand_fields(MODE_W'($urandom_range(0, 7))), 1'b0, '0);
    end
  endtask

  // result sink backpressure
  always @(posedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result word at %0t: char %02h attr %02h col %0d row %0d",
                   $time, rsp_ch.data.cell_char, rsp_ch.data.cell_attr,
                   rsp_ch.data.cursor_col, rsp_ch.data.cursor_row);
        end
        mismatches++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (rsp_ch.data.cell_char !== want_rsp.cell_char ||
            rsp_ch.data.cell_attr !== want_rsp.cell_attr ||
            rsp_ch.data.cursor_col !== want_rsp.cursor_col ||
            rsp_ch.data.cursor_row !== want_rsp.cursor_row) begin
          if (mismatches < 10) begin
            $display({"mismatch at %0t: want char %02h attr %02h col %0d row %0d,",
                      " got char %02h attr %02h col %0d row %0d"},
                     $time, want_rsp.cell_char, want_rsp.cell_attr, want_rsp.cursor_col,
                     want_rsp.cursor_row, rsp_ch.data.cell_char, rsp_ch.data.cell_attr,
                     rsp_ch.data.cursor_col, rsp_ch.data.cursor_row);
          end
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [ATTR_W-1:0] fill_vals [PHASES];
    rst           = 1'b1;
    steady        = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    model_scrolls = 0;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.data   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    model_attr = RESET_ATTR;
    wipe_screen();

    fill_vals[0] = 8'h00;
    fill_vals[1] = 8'hFF;
    fill_vals[2] = ATTR_W'($urandom);
    fill_vals[3] = 8'h5A;
    fill_vals[4] = ATTR_W'($urandom);
    fill_vals[5] = RESET_ATTR;

    // directed words: reset state, extremes and corner cases
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd0, 1,
                           BLANK_CHAR, RESET_ATTR, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'hFF, 32'hFFFFFFFF, 5'd31, 7'd127, 1,
                           8'h00, 8'h00, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_DEL, 8'h00, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_PUT, 8'h41, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd1, 5'd0));
    dir_tab.push_back(drow(MODE_PUT, NUL_CHAR, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd1, 5'd0));
    dir_tab.push_back(drow(MODE_PUT, 8'hFF, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd2, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd1, 1,
                           8'hFF, RESET_ATTR, 7'd2, 5'd0));
    dir_tab.push_back(drow(MODE_DEL, 8'h00, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd1, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd1, 1,
                           BLANK_CHAR, RESET_ATTR, 7'd1, 5'd0));
    dir_tab.push_back(drow(MODE_TAB, 8'h00, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd9, 5'd0));
    dir_tab.push_back(drow(MODE_HEX, 8'h00, 32'hDEADBEEF, 5'd0, 7'd0, 1,
                           8'h00, 8'h00, 7'd19, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd9, 1,
                           ZERO_CHAR, RESET_ATTR, 7'd19, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd18, 1,
                           8'h46, RESET_ATTR, 7'd19, 5'd0));
    dir_tab.push_back(drow(MODE_PUT, NEWLINE_CHAR, 32'h0, 5'd0, 7'd0, 1,
                           8'h00, 8'h00, 7'd0, 5'd1));
    // delete at column zero goes back to the end of the previous row
    dir_tab.push_back(drow(MODE_DEL, 8'h00, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd79, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd79, 1,
                           BLANK_CHAR, RESET_ATTR, 7'd79, 5'd0));
    // tab past the last column moves to the next line
    dir_tab.push_back(drow(MODE_TAB, 8'h00, 32'h0, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd0, 5'd1));
    dir_tab.push_back(drow(MODE_HEX, 8'h00, 32'h00000000, 5'd0, 7'd0, 1,
                           8'h00, 8'h00, 7'd10, 5'd1));
    dir_tab.push_back(drow(MODE_HEX, 8'h00, 32'hFFFFFFFF, 5'd0, 7'd0, 1,
                           8'h00, 8'h00, 7'd20, 5'd1));
    dir_tab.push_back(drow(MODE_SPARE6, 8'h5A, 32'h12345678, 5'd3, 7'd4, 1,
                           8'h00, 8'h00, 7'd20, 5'd1));
    dir_tab.push_back(drow(MODE_SPARE7, 8'hFF, 32'hFFFFFFFF, 5'd31, 7'd127, 1,
                           8'h00, 8'h00, 7'd20, 5'd1));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd1, 7'd19, 0, 8'h00, 8'h00, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_CLEAR, 8'h00, 32'h0, 5'd0, 7'd0, 1,
                           8'h00, 8'h00, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd24, 7'd79, 1,
                           BLANK_CHAR, RESET_ATTR, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd25, 7'd0, 1, 8'h00, 8'h00, 7'd0, 5'd0));
    dir_tab.push_back(drow(MODE_READ, 8'h00, 32'h0, 5'd0, 7'd80, 1, 8'h00, 8'h00, 7'd0, 5'd0));

    // reset
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);

    // random phases, each under its own fill attribute
    for (int p = 0; p < PHASES; p++) begin
      write_fill(fill_vals[p]);
      steady = (p == STEADY_PHASE);
      while (words_sent < dir_tab.size() + (p + 1) * PHASE_WORDS) run_sequence();
    end
    steady = 1'b0;

    // drain
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ text_console_writer_unit.f @@
src/ctw_pkg.sv
src/ctw_ifs.sv
src/ctw_cell_ram.sv
src/ctw_addr_unit.sv
src/ctw_seq.sv
src/text_console_writer_unit.sv
sim/text_console_writer_unit_test.sv
